// ----- rtl/core/bfha_pkg.sv -----
// Shared types and constants of the best-fit heap allocator.
// Used by the front end, the request queue, the back end and the top level.
package bfha_pkg;

	localparam int FREE_ENTRIES_DEF = 32;
	localparam int USED_ENTRIES_DEF = 64;
	localparam int QUEUE_DEPTH      = 2;
	localparam int CFG_IDX_W        = 1;

	localparam logic [32:0] CAP_ROUND   = 33'h0f;
	localparam logic [32:0] CAP_MASK    = ~33'h0f;
	localparam logic [31:0] SPLIT_MIN   = 32'h20;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_QUERY   = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_OOM       = 3'd1,
		STAT_TABLE_FUL = 3'd2,
		STAT_NOT_FOUND = 3'd3,
		STAT_FREE_FULL = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		CFG_HEAP_BASE  = 1'd0,
		CFG_HEAP_LIMIT = 1'd1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FSCAN,
		S_FDONE,
		S_USCAN,
		S_COMMIT,
		S_OUT
	} state_t;

	// Classified request handed from the front end to the back end.
	typedef struct packed {
		op_t         op;
		logic [31:0] size;
		logic [31:0] cap;
		logic        cap_oom;
		logic        fill;
		logic [31:0] addr;
	} req_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] size;
		logic [31:0] clear;
		status_t     status;
	} res_t;

	// Handshake between queue and back end.
	typedef struct packed {
		logic valid;
		logic ready;
	} hs_t;

endpackage

// ----- rtl/core/best_fit_heap_allocator_top.sv -----
// Top level of the best-fit heap allocator: stream ports, configuration port, assertions.
// Instantiates bfha_front, bfha_queue and bfha_back; depends on bfha_pkg.

// Each operation is handled one at a time by a sequencer. An allocate or release walks
// the free table (FREE_ENTRIES reads) and then the allocation table (USED_ENTRIES reads),
// one entry per cycle through registered memory ports; a query walks only the allocation
// table, and opcode three walks neither. A two-entry queue lets up to three requests be
// taken while one is in work. Ties among equal free sizes go to the block freed earliest;
// freed blocks are never merged. Writing heap_base also reloads the bump pointer. No
// clearing pass is needed after reset.
module best_fit_heap_allocator_top import bfha_pkg::*; #(
	parameter int FREE_ENTRIES = FREE_ENTRIES_DEF,
	parameter int USED_ENTRIES = USED_ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [71:0]          s_tdata,  // request_size, zero_fill, block_address, zero pad
	input  logic [1:0]           s_tuser,  // opcode
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [95:0]          m_tdata,  // result_address, result_size, clear_bytes
	output logic [2:0]           m_tuser,  // status
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	logic fr_valid, q_ready;
	req_t fr_req, q_req;
	hs_t  q_hs;
	logic pop;
	res_t res;

	assign cfg_ready = 1'b1;

	bfha_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.opcode        (s_tuser),
		.request_size  (s_tdata[31:0]),
		.zero_fill     (s_tdata[32]),
		.block_address (s_tdata[64:33]),
		.req_valid     (fr_valid),
		.req_ready     (q_ready),
		.req           (fr_req)
	);

	bfha_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (q_ready),
		.push_data  (fr_req),
		.pop_hs     (q_hs),
		.pop_ready  (pop),
		.pop_data   (q_req)
	);

	bfha_back #(
		.FREE_ENTRIES (FREE_ENTRIES),
		.USED_ENTRIES (USED_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_hs    (q_hs),
		.req_pop   (pop),
		.req       (q_req),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {res.clear, res.size, res.addr};
	assign m_tuser = res.status;

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser <= STAT_FREE_FULL))
		else $error("status code out of range");

	a_addr_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[31:0] != 32'd0) |-> (m_tuser == STAT_OK))
		else $error("address returned with failing status");

	a_clear_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[95:64] != 32'd0) |->
			(m_tuser == STAT_OK && m_tdata[67:64] == 4'd0))
		else $error("clear length not an aligned capacity");

	a_size_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[63:32] != 32'd0) |->
			(m_tuser == STAT_OK && m_tdata[31:0] == 32'd0))
		else $error("query size with allocation result");

endmodule

// ----- rtl/core/bfha_front.sv -----
// Front end: takes input transfers, derives the rounded capacity and registers the request.
// Depends on bfha_pkg.
module bfha_front import bfha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [31:0] request_size,
	input  logic        zero_fill,
	input  logic [31:0] block_address,
	output logic        req_valid,
	input  logic        req_ready,
	output req_t        req
);

	logic        v_q;
	req_t        r_q;
	logic [31:0] size_eff;
	logic [32:0] cap33;

	assign size_eff = (request_size == 32'd0) ? 32'd1 : request_size;
	assign cap33    = ({1'b0, size_eff} + CAP_ROUND) & CAP_MASK;
	assign in_ready = !v_q || req_ready;
	assign req_valid = v_q;
	assign req = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			r_q.op      <= op_t'(opcode);
			r_q.size    <= size_eff;
			r_q.cap     <= cap33[31:0];
			r_q.cap_oom <= cap33[32];
			r_q.fill    <= zero_fill;
			r_q.addr    <= block_address;
		end
	end

endmodule

// ----- rtl/core/bfha_queue.sv -----
// Short request queue between the front end and the back end.
// Depends on bfha_pkg.
module bfha_queue import bfha_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  req_t push_data,
	output hs_t  pop_hs,
	input  logic pop_ready,
	output req_t pop_data
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PW:0] FULL = (PW + 1)'(QUEUE_DEPTH);

	req_t        mem [QUEUE_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;
	logic          push, pop;

	assign push_ready   = cnt_q != FULL;
	assign push         = push_valid && push_ready;
	assign pop_hs.valid = cnt_q != '0;
	assign pop_hs.ready = pop_ready;
	assign pop          = pop_hs.valid && pop_ready;
	assign pop_data     = mem[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW + 1)'(push) - (PW + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= push_data;
		end
	end

endmodule

// ----- rtl/core/bfha_back.sv -----
// Back end: sequencer that scans the free and allocation tables and commits each operation.
// Holds the table memories, the bump pointer and the result register. Depends on bfha_pkg.
module bfha_back import bfha_pkg::*; #(
	parameter int FREE_ENTRIES = FREE_ENTRIES_DEF,
	parameter int USED_ENTRIES = USED_ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  hs_t                  req_hs,
	output logic                 req_pop,
	input  req_t                 req,
	output logic                 out_valid,
	input  logic                 out_ready,
	output res_t                 out_res
);

	localparam int FW = $clog2(FREE_ENTRIES);
	localparam int UW = $clog2(USED_ENTRIES);
	localparam logic [FW:0] FCNT = (FW + 1)'(FREE_ENTRIES);
	localparam logic [UW:0] UCNT = (UW + 1)'(USED_ENTRIES);

	state_t state_q, state_d;

	logic [31:0] heap_limit_q, bump_q, seq_q;

	// Free table: sizes, starts and insertion stamps in memory, valid bits in flops.
	logic [31:0] f_size_mem  [FREE_ENTRIES];
	logic [31:0] f_start_mem [FREE_ENTRIES];
	logic [31:0] f_stamp_mem [FREE_ENTRIES];
	logic [FREE_ENTRIES-1:0] f_valid_q;
	logic [31:0] f_size_rd, f_start_rd, f_stamp_rd;

	logic [31:0] u_start_mem [USED_ENTRIES];
	logic [31:0] u_req_mem   [USED_ENTRIES];
	logic [31:0] u_cap_mem   [USED_ENTRIES];
	logic [USED_ENTRIES-1:0] u_valid_q;
	logic [31:0] u_start_rd, u_req_rd, u_cap_rd;

	logic [FW:0]   fcnt_q;
	logic [UW:0]   ucnt_q;
	logic          f_rd_s1, u_rd_s1, fv_s1, uv_s1;
	logic [FW-1:0] f_idx_s1;
	logic [UW-1:0] u_idx_s1;

	req_t          cur_q;
	logic          best_found_q, fempty_found_q;
	logic [FW-1:0] best_idx_q, fempty_idx_q;
	logic [31:0]   best_size_q, best_start_q, best_stamp_q;
	logic          umatch_q, uempty_found_q;
	logic [UW-1:0] umatch_idx_q, uempty_idx_q;
	logic [31:0]   umatch_req_q, umatch_cap_q;
	logic [31:0]   addr_q, blk_cap_q, rem_q;
	logic          done_q;
	res_t          res_q;
	logic          out_v_q;

	logic f_issue, u_issue, out_free, cand_better;
	logic [32:0] bump_sum;

	// Free write port.
	logic          f_we;
	logic [FW-1:0] f_wa;
	logic [31:0]   f_wsize, f_wstart;
	logic          u_we;
	logic [UW-1:0] u_wa;

	assign out_free  = !out_v_q || out_ready;
	assign out_valid = out_v_q;
	assign bump_sum  = {1'b0, bump_q} + {1'b0, cur_q.cap};

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_hs.valid) begin
					unique case (req.op)
						OP_NOP:   state_d = S_OUT;
						OP_QUERY: state_d = S_USCAN;
						default:  state_d = S_FSCAN;
					endcase
				end
			end
			S_FSCAN:  if (fcnt_q == FCNT && !f_rd_s1) state_d = S_FDONE;
			S_FDONE:  state_d = S_USCAN;
			S_USCAN:  if (ucnt_q == UCNT && !u_rd_s1) state_d = S_COMMIT;
			S_COMMIT: state_d = S_OUT;
			S_OUT:    if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		req_pop = (state_q == S_IDLE) && req_hs.valid;
		f_issue = (state_q == S_FSCAN) && (fcnt_q != FCNT);
		u_issue = (state_q == S_USCAN) && (ucnt_q != UCNT);
	end

	always_comb begin
		cand_better = fv_s1 && (cur_q.op == OP_ALLOC) && (f_size_rd >= cur_q.cap) &&
			(!best_found_q || (f_size_rd < best_size_q) ||
			 ((f_size_rd == best_size_q) && (f_stamp_rd < best_stamp_q)));
	end

	// Commit write ports.
	always_comb begin
		f_we     = 1'b0;
		f_wa     = best_idx_q;
		f_wsize  = rem_q;
		f_wstart = addr_q + cur_q.cap;
		u_we     = 1'b0;
		u_wa     = umatch_q ? umatch_idx_q : uempty_idx_q;
		if (state_q == S_COMMIT && !done_q) begin
			unique case (cur_q.op)
				OP_ALLOC: begin
					u_we = umatch_q || uempty_found_q;
					f_we = u_we && best_found_q && (rem_q >= SPLIT_MIN);
				end
				OP_RELEASE: begin
					f_wa     = fempty_idx_q;
					f_wsize  = umatch_cap_q;
					f_wstart = cur_q.addr;
					f_we     = umatch_q && (umatch_cap_q != 32'd0) && fempty_found_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (f_we) begin
			f_size_mem[f_wa]  <= f_wsize;
			f_start_mem[f_wa] <= f_wstart;
			f_stamp_mem[f_wa] <= seq_q;
		end
		f_size_rd  <= f_size_mem[fcnt_q[FW-1:0]];
		f_start_rd <= f_start_mem[fcnt_q[FW-1:0]];
		f_stamp_rd <= f_stamp_mem[fcnt_q[FW-1:0]];
		if (u_we) begin
			u_start_mem[u_wa] <= addr_q;
			u_req_mem[u_wa]   <= cur_q.size;
			u_cap_mem[u_wa]   <= blk_cap_q;
		end
		u_start_rd <= u_start_mem[ucnt_q[UW-1:0]];
		u_req_rd   <= u_req_mem[ucnt_q[UW-1:0]];
		u_cap_rd   <= u_cap_mem[ucnt_q[UW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			heap_limit_q <= '0;
			bump_q       <= '0;
			seq_q        <= '0;
			f_valid_q    <= '0;
			u_valid_q    <= '0;
			fcnt_q       <= '0;
			ucnt_q       <= '0;
			f_rd_s1      <= 1'b0;
			u_rd_s1      <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			f_rd_s1 <= f_issue;
			u_rd_s1 <= u_issue;
			if (f_issue) fcnt_q <= fcnt_q + 1'b1;
			if (u_issue) ucnt_q <= ucnt_q + 1'b1;
			if (state_q == S_IDLE) begin
				fcnt_q <= '0;
				ucnt_q <= '0;
			end
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_HEAP_BASE:  bump_q <= cfg_data;
					CFG_HEAP_LIMIT: heap_limit_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_COMMIT && !done_q) begin
				unique case (cur_q.op)
					OP_ALLOC: begin
						if (u_we) begin
							u_valid_q[u_wa] <= 1'b1;
							if (!best_found_q) begin
								bump_q <= addr_q + cur_q.cap;
							end else if (rem_q >= SPLIT_MIN) begin
								seq_q <= seq_q + 1'b1;
							end else begin
								f_valid_q[best_idx_q] <= 1'b0;
							end
						end
					end
					OP_RELEASE: begin
						if (umatch_q && (umatch_cap_q == 32'd0 || fempty_found_q)) begin
							u_valid_q[umatch_idx_q] <= 1'b0;
						end
						if (f_we) begin
							f_valid_q[fempty_idx_q] <= 1'b1;
							seq_q <= seq_q + 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (state_q == S_OUT && out_free) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Scan trackers and result assembly.
	always_ff @(posedge clk) begin
		fv_s1    <= f_valid_q[fcnt_q[FW-1:0]];
		uv_s1    <= u_valid_q[ucnt_q[UW-1:0]];
		f_idx_s1 <= fcnt_q[FW-1:0];
		u_idx_s1 <= ucnt_q[UW-1:0];
		if (state_q == S_OUT && out_free) begin
			out_res <= res_q;
		end
		unique case (state_q)
			S_IDLE: begin
				cur_q          <= req;
				best_found_q   <= 1'b0;
				fempty_found_q <= 1'b0;
				umatch_q       <= 1'b0;
				uempty_found_q <= 1'b0;
				done_q         <= 1'b0;
				addr_q         <= req.addr;
				res_q          <= '{addr: '0, size: '0, clear: '0, status: STAT_OK};
			end
			S_FSCAN: begin
				if (f_rd_s1) begin
					if (cand_better) begin
						best_found_q <= 1'b1;
						best_idx_q   <= f_idx_s1;
						best_size_q  <= f_size_rd;
						best_start_q <= f_start_rd;
						best_stamp_q <= f_stamp_rd;
					end
					if (!fv_s1 && !fempty_found_q) begin
						fempty_found_q <= 1'b1;
						fempty_idx_q   <= f_idx_s1;
					end
				end
			end
			S_FDONE: begin
				rem_q <= best_size_q - cur_q.cap;
				if (cur_q.op == OP_ALLOC) begin
					if (cur_q.cap_oom) begin
						done_q        <= 1'b1;
						res_q.status  <= STAT_OOM;
					end else if (best_found_q) begin
						addr_q    <= best_start_q;
						blk_cap_q <= (best_size_q - cur_q.cap >= SPLIT_MIN) ?
							cur_q.cap : best_size_q;
					end else if (bump_sum > {1'b0, heap_limit_q}) begin
						done_q       <= 1'b1;
						res_q.status <= STAT_OOM;
					end else begin
						addr_q    <= bump_q;
						blk_cap_q <= cur_q.cap;
					end
				end else if (cur_q.addr == 32'd0) begin
					done_q       <= 1'b1;
					res_q.status <= STAT_NOT_FOUND;
				end
			end
			S_USCAN: begin
				if (u_rd_s1) begin
					if (uv_s1 && !umatch_q && u_start_rd == addr_q) begin
						umatch_q     <= 1'b1;
						umatch_idx_q <= u_idx_s1;
						umatch_req_q <= u_req_rd;
						umatch_cap_q <= u_cap_rd;
					end
					if (!uv_s1 && !uempty_found_q) begin
						uempty_found_q <= 1'b1;
						uempty_idx_q   <= u_idx_s1;
					end
				end
			end
			S_COMMIT: begin
				if (!done_q) begin
					unique case (cur_q.op)
						OP_ALLOC: begin
							if (umatch_q || uempty_found_q) begin
								res_q.addr  <= addr_q;
								res_q.clear <= cur_q.fill ? blk_cap_q : 32'd0;
							end else begin
								res_q.status <= STAT_TABLE_FUL;
							end
						end
						OP_RELEASE: begin
							if (!umatch_q) begin
								res_q.status <= STAT_NOT_FOUND;
							end else if (umatch_cap_q != 32'd0 && !fempty_found_q) begin
								res_q.status <= STAT_FREE_FULL;
							end
						end
						OP_QUERY: begin
							if (umatch_q) begin
								res_q.size <= umatch_req_q;
							end else begin
								res_q.status <= STAT_NOT_FOUND;
							end
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- tb/bfha_checker.sv -----
// Checker for the best-fit heap allocator: watches the request, result and register
// channels, predicts every result and compares it field by field. Depends on bfha_pkg.
module bfha_checker import bfha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [95:0] m_tdata,
	input  logic [2:0]  m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NF = FREE_ENTRIES_DEF;
	localparam int NU = USED_ENTRIES_DEF;

	logic [31:0] limit_q, bump_q;
	logic [31:0] fsize[NF], fstart[NF];
	logic        fvalid[NF];
	int          fage[NF];
	logic [31:0] ustart[NU], ureq[NU], ucap[NU];
	logic        uvalid[NU];

	res_t expected_results[$];

	function automatic int lookup_used(logic [31:0] a);
		for (int i = 0; i < NU; i++)
			if (uvalid[i] && ustart[i] == a) return i;
		return -1;
	endfunction

	function automatic void add_free(int k, logic [31:0] sz, logic [31:0] st);
		fvalid[k] = 1'b0;
		for (int i = 0; i < NF; i++)
			if (fvalid[i]) fage[i]++;
		fsize[k] = sz;
		fstart[k] = st;
		fage[k] = 0;
		fvalid[k] = 1'b1;
	endfunction

	function automatic res_t serve(op_t op, logic [31:0] sz, logic fill, logic [31:0] a);
		res_t r;
		logic [32:0] cap33;
		logic [31:0] cap, addr, bcap, rem;
		int best, slot, u, k;
		r = '{addr: 32'd0, size: 32'd0, clear: 32'd0, status: STAT_OK};
		case (op)
			OP_ALLOC: begin
				if (sz == 0) sz = 32'd1;
				cap33 = ({1'b0, sz} + 33'h0f) & ~33'h0f;
				if (cap33[32]) begin
					r.status = STAT_OOM;
					return r;
				end
				cap = cap33[31:0];
				best = -1;
				rem = 0;
				for (int i = 0; i < NF; i++) begin
					if (!fvalid[i] || fsize[i] < cap) continue;
					if (best < 0 || fsize[i] < fsize[best] ||
					    (fsize[i] == fsize[best] && fage[i] > fage[best]))
						best = i;
				end
				if (best >= 0) begin
					addr = fstart[best];
					rem = fsize[best] - cap;
					bcap = (rem >= 32'h20) ? cap : fsize[best];
				end else begin
					if ({1'b0, bump_q} + cap33 > {1'b0, limit_q}) begin
						r.status = STAT_OOM;
						return r;
					end
					addr = bump_q;
					bcap = cap;
				end
				slot = lookup_used(addr);
				if (slot < 0)
					for (int i = 0; i < NU; i++)
						if (!uvalid[i]) begin
							slot = i;
							break;
						end
				if (slot < 0) begin
					r.status = STAT_TABLE_FUL;
					return r;
				end
				if (best >= 0) begin
					if (rem >= 32'h20) add_free(best, rem, addr + cap);
					else fvalid[best] = 1'b0;
				end else begin
					bump_q = addr + cap;
				end
				ustart[slot] = addr;
				ureq[slot] = sz;
				ucap[slot] = bcap;
				uvalid[slot] = 1'b1;
				r.addr = addr;
				r.clear = fill ? bcap : 32'd0;
			end
			OP_RELEASE: begin
				u = (a == 0) ? -1 : lookup_used(a);
				if (u < 0) begin
					r.status = STAT_NOT_FOUND;
					return r;
				end
				if (ucap[u] != 0) begin
					k = -1;
					for (int i = 0; i < NF; i++)
						if (!fvalid[i]) begin
							k = i;
							break;
						end
					if (k < 0) begin
						r.status = STAT_FREE_FULL;
						return r;
					end
					add_free(k, ucap[u], a);
				end
				uvalid[u] = 1'b0;
			end
			OP_QUERY: begin
				u = lookup_used(a);
				if (u >= 0) r.size = ureq[u];
				else r.status = STAT_NOT_FOUND;
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t got, exp_r;
		if (!arst_n) begin
			limit_q = 0;
			bump_q = 0;
			errors = 0;
			pending = 0;
			for (int i = 0; i < NF; i++) fvalid[i] = 1'b0;
			for (int i = 0; i < NU; i++) uvalid[i] = 1'b0;
			expected_results.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_HEAP_BASE) begin
					bump_q = cfg_data;
				end else begin
					limit_q = cfg_data;
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(serve(op_t'(s_tuser), s_tdata[31:0],
					s_tdata[32], s_tdata[64:33]));
			if (m_tvalid && m_tready) begin
				got = '{addr: m_tdata[31:0], size: m_tdata[63:32],
					clear: m_tdata[95:64], status: status_t'(m_tuser)};
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected");
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (got.addr !== exp_r.addr) begin
						$error("result_address expected %h got %h", exp_r.addr, got.addr);
						errors++;
					end
					if (got.size !== exp_r.size) begin
						$error("result_size expected %h got %h", exp_r.size, got.size);
						errors++;
					end
					if (got.clear !== exp_r.clear) begin
						$error("clear_bytes expected %h got %h", exp_r.clear, got.clear);
						errors++;
					end
					if (got.status !== exp_r.status) begin
						$error("status expected %0d got %0d", exp_r.status, got.status);
						errors++;
					end
				end
			end
			pending = expected_results.size();
		end
	end
endmodule

// ----- tb/best_fit_heap_allocator_top_test.sv -----
// Stimulus and verdict for the best-fit heap allocator: directed requests, table stress
// and random phases under several heap settings. Depends on bfha_pkg and bfha_checker.
module best_fit_heap_allocator_top_test import bfha_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0, arst_n = 1'b0;
	logic        s_tvalid = 1'b0, s_tready;
	logic [71:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid, m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_valid = 1'b0, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int          errors, pending, quiet_cycles = 0;
	bit          no_idle = 1'b0;
	logic [31:0] handed_out[$];

	best_fit_heap_allocator_top dut (.*);

	bfha_checker u_checker (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Collect granted addresses so that releases and queries hit live blocks.
	always @(posedge clk) begin
		if (m_tvalid && m_tready && m_tdata[31:0] != 0) handed_out.push_back(m_tdata[31:0]);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= 6000) begin
			$display("best_fit_heap_allocator_top_test: done, errors");
			$finish;
		end
	end

	// Receiver stalls come in bursts.
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (!no_idle && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 18);
				m_tready = 1'b0;
				repeat (n) @(negedge clk);
			end
			m_tready = 1'b1;
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Registers change only once every result has come back.
	task automatic settle_and_set(logic [31:0] b, logic [31:0] lim);
		wait (pending == 0);
		repeat (150) @(negedge clk);
		write_reg(CFG_HEAP_BASE, b);
		write_reg(CFG_HEAP_LIMIT, lim);
	endtask

	task automatic send_request(op_t op, logic [31:0] sz, logic fill, logic [31:0] a);
		int n;
		@(negedge clk);
		if (!no_idle && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 18);
			s_tvalid = 1'b0;
			repeat (n) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = {7'd0, a, fill, sz};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	function automatic logic [31:0] pick_live();
		if (handed_out.size() == 0 || $urandom_range(0, 9) == 0) return $urandom();
		return handed_out[$urandom_range(0, handed_out.size() - 1)];
	endfunction

	function automatic logic [31:0] pick_size();
		case ($urandom_range(0, 19))
			0:       return $urandom();
			1:       return 32'hffff_fff0 + $urandom_range(0, 15);
			2, 3:    return $urandom_range(0, 4096);
			default: return $urandom_range(0, 200);
		endcase
	endfunction

	task automatic random_phase(int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				send_request(OP_ALLOC, pick_size(), 1'($urandom_range(0, 1)), $urandom());
			else if (r < 75)
				send_request(OP_RELEASE, $urandom(), 1'($urandom_range(0, 1)), pick_live());
			else if (r < 95)
				send_request(OP_QUERY, $urandom(), 1'($urandom_range(0, 1)), pick_live());
			else
				send_request(OP_NOP, $urandom(), 1'($urandom_range(0, 1)), $urandom());
		end
		stop_sending();
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Empty heap: everything fails or is unknown; opcode three does nothing.
		send_request(OP_ALLOC, 32'd0, 1'b1, 32'd0);
		send_request(OP_NOP, 32'hffff_ffff, 1'b1, 32'hffff_ffff);
		send_request(OP_QUERY, 32'd0, 1'b0, 32'd0);
		send_request(OP_RELEASE, 32'd0, 1'b0, 32'd0);
		stop_sending();

		settle_and_set(32'h100, 32'hffff_ffff);
		send_request(OP_ALLOC, 32'hffff_ffff, 1'b1, 32'd0);
		send_request(OP_ALLOC, 32'hffff_fff0, 1'b1, 32'd0);
		send_request(OP_ALLOC, 32'd0, 1'b1, 32'd0);
		send_request(OP_ALLOC, 32'd100, 1'b1, 32'd0);
		send_request(OP_ALLOC, 32'd200, 1'b0, 32'd0);
		send_request(OP_ALLOC, 32'd100, 1'b0, 32'd0);
		stop_sending();
		wait (pending == 0);
		// Two equal free blocks, then a split and a whole-block grant.
		send_request(OP_RELEASE, 32'd0, 1'b0, 32'h110);
		send_request(OP_RELEASE, 32'd0, 1'b0, 32'h250);
		send_request(OP_ALLOC, 32'd20, 1'b1, 32'd0);
		send_request(OP_ALLOC, 32'd70, 1'b1, 32'd0);
		send_request(OP_ALLOC, 32'd112, 1'b1, 32'd0);
		send_request(OP_QUERY, 32'd0, 1'b0, 32'h180);
		send_request(OP_QUERY, 32'd0, 1'b0, 32'h100);
		send_request(OP_RELEASE, 32'd0, 1'b0, 32'h110);
		send_request(OP_RELEASE, 32'd0, 1'b0, 32'h110);
		send_request(OP_QUERY, 32'd0, 1'b0, 32'hdead_beef);
		stop_sending();

		// Fill the allocation table, then overflow the free table.
		settle_and_set(32'h1_0000, 32'h2_0000);
		for (int i = 0; i < 66; i++) send_request(OP_ALLOC, 32'd16, 1'b1, 32'd0);
		for (int i = 0; i < 35; i++)
			send_request(OP_RELEASE, 32'd0, 1'b0, 32'h1_0000 + 32'(16 * i));
		stop_sending();
		// After the base is reloaded, these allocations are served from free-table blocks, not the bump pointer.
		settle_and_set(32'h1_0000, 32'h2_0000);
		for (int i = 0; i < 4; i++) send_request(OP_ALLOC, 32'd16, 1'b0, 32'd0);
		send_request(OP_QUERY, 32'd0, 1'b0, 32'h1_0230);
		stop_sending();

		settle_and_set(32'h1000, 32'h5000);
		random_phase(150);
		settle_and_set(32'hffff_0000, 32'hffff_ffff);
		random_phase(130);
		settle_and_set(32'h10, 32'h8000_0000);
		random_phase(130);
		no_idle = 1'b1;
		settle_and_set(32'h2000, 32'h3000);
		random_phase(80);

		wait (pending == 0);
		repeat (150) @(negedge clk);
		if (errors == 0)
			$display("best_fit_heap_allocator_top_test: done, clean");
		else
			$display("best_fit_heap_allocator_top_test: done, errors");
		$finish;
	end
endmodule
